### rtl/vln_pkg.sv
// ----------------------------------------------------------------------------
// vln_pkg
// Shared types and constants for the vector layer normalize unit.
// ----------------------------------------------------------------------------
package vln_pkg;

   localparam int MAX_LEN_DEF = 64;

   localparam int SAMPLE_W = 16;
   localparam int LEN_W    = 7;
   localparam int EPS_W    = 16;
   localparam int PADDR_W  = 3;
   localparam int PDATA_W  = 32;

   localparam int SUM_W    = 22;
   localparam int DIFF_W   = 30;
   localparam int MAG_W    = 29;
   localparam int MEAN_W   = 29;
   localparam int INV_W    = 32;
   localparam int PROD_W   = MAG_W + INV_W;
   localparam int ACC_W    = 63;
   localparam int DVD_W    = 63;
   localparam int DVS_W    = 34;
   localparam int VAR_W    = 33;

   localparam logic [LEN_W-1:0] LEN_RESET = 7'd64;
   localparam logic [EPS_W-1:0] EPS_RESET = 16'd168;

   localparam logic REG_LENGTH  = 1'b0;
   localparam logic REG_EPSILON = 1'b1;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_MEAN,
      ST_READ,
      ST_DIFF,
      ST_MUL,
      ST_ACC,
      ST_VAR,
      ST_RECIP,
      ST_SQRT,
      ST_EMIT,
      ST_WAIT
   } state_type;

endpackage

### rtl/vln_ram.sv
// ----------------------------------------------------------------------------
// vln_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module vln_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/vector_layer_normalize_unit.sv
// Samples load while the unit is idle; a new vector is not accepted until the last
// result beat of the previous one is taken (rsp stalls hold each result beat).
// Processing is sequential, one vector at a time, set by the shared bit-serial divider
// (three divides), the 32-step root and the two passes over the elements.
// Reset clears configuration, the load count, the running sum and control; the sample store is not cleared.
// ----------------------------------------------------------------------------
// vector_layer_normalize_unit
// Layer normalization without affine terms over a stored vector of samples.
// ----------------------------------------------------------------------------
module vector_layer_normalize_unit
   import vln_pkg::*;
#(
   parameter int MAX_LEN = MAX_LEN_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic signed [SAMPLE_W-1:0] req_sample,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [SAMPLE_W-1:0] rsp_normalized_value,
   output logic                       rsp_last,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [PADDR_W-1:0]         paddr,
   input  logic [PDATA_W-1:0]         pwdata,
   output logic [PDATA_W-1:0]         prdata,
   output logic                       pready
);

   localparam int AW = $clog2(MAX_LEN);
   localparam int CW = $clog2(MAX_LEN + 1);

   state_type state_ff, state_in;

   logic [LEN_W-1:0]        len_ff, len_in;
   logic [EPS_W-1:0]        eps_ff, eps_in;
   logic [CW-1:0]           load_cnt_ff, load_cnt_in;
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic [CW-1:0]           n_ff, n_in;
   logic [AW-1:0]           idx_ff, idx_in;
   logic                    pass_ff, pass_in;
   logic signed [MEAN_W-1:0] mean_ff, mean_in;
   logic [MAG_W-1:0]        a_ff, a_in;
   logic                    neg_ff, neg_in;
   logic [PROD_W-1:0]       mul_ff, mul_in;
   logic [ACC_W-1:0]        acc_ff, acc_in;
   logic [INV_W-1:0]        inv_ff, inv_in;
   logic [DVS_W-1:0]        div_rem_ff, div_rem_in;
   logic [DVD_W-1:0]        div_quo_ff, div_quo_in;
   logic [DVS_W-1:0]        div_den_ff, div_den_in;
   logic [5:0]              div_cnt_ff, div_cnt_in;
   logic [DVD_W-1:0]        sq_v_ff, sq_v_in;
   logic [DVD_W-1:0]        sq_res_ff, sq_res_in;
   logic [DVD_W-1:0]        sq_bit_ff, sq_bit_in;
   logic [4:0]              sq_cnt_ff, sq_cnt_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_W-1:0]     rsp_value_ff, rsp_value_in;
   logic                    rsp_last_ff, rsp_last_in;

   logic                    accept;
   logic                    cfg_write;
   logic [CW-1:0]           eff_len;
   logic [CW-1:0]           cnt_next;
   logic signed [SUM_W-1:0] sum_next;
   logic [SUM_W-1:0]        sum_abs;
   logic [DVS_W-1:0]        mean_dvd;
   logic                    rd_en;
   logic [SAMPLE_W-1:0]     rd_data;
   logic [DVS_W:0]          rem_sh;
   logic                    div_ge;
   logic [DVS_W:0]          rem_sub;
   logic [DVD_W-1:0]        quo_next;
   logic [DVS_W-1:0]        rem_next;
   logic signed [DIFF_W-1:0] diff;
   logic [DIFF_W-1:0]       diff_abs;
   logic [ACC_W-1:0]        acc_sum;
   logic [DVS_W-1:0]        v_sum;
   logic [DVD_W-1:0]        sq_rb;
   logic                    sq_ge;
   logic [DVD_W-1:0]        sq_res_next;
   logic [PROD_W:0]         rnd;
   logic [DIFF_W-1:0]       q;
   logic                    is_last;
   logic [MAG_W-1:0]        mean_mag;

   vln_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (MAX_LEN)
   ) u_store (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (load_cnt_ff[AW-1:0]),
      .wr_data (req_sample),
      .rd_en   (rd_en),
      .rd_addr (idx_ff),
      .rd_data (rd_data)
   );

   assign req_stall            = (state_ff != ST_LOAD);
   assign accept               = req_valid && !req_stall;
   assign cfg_write            = psel && penable && pwrite;
   assign pready               = 1'b1;
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_normalized_value = rsp_value_ff;
   assign rsp_last             = rsp_last_ff;

   always_comb begin
      case (paddr[2])
         REG_LENGTH:  prdata = PDATA_W'(len_ff);
         REG_EPSILON: prdata = PDATA_W'(eps_ff);
         default:     prdata = '0;
      endcase
   end

   always_comb begin
      if (len_ff == '0) begin
         eff_len = CW'(1);
      end else if (len_ff > LEN_W'(MAX_LEN)) begin
         eff_len = CW'(MAX_LEN);
      end else begin
         eff_len = len_ff[CW-1:0];
      end
      cnt_next = load_cnt_ff + CW'(1);
      sum_next = sum_ff + SUM_W'(req_sample);
      sum_abs  = sum_next[SUM_W-1] ? SUM_W'(-sum_next) : SUM_W'(sum_next);
      mean_dvd = {sum_abs, 12'b0} + DVS_W'(cnt_next >> 1);

      rem_sh   = {div_rem_ff, div_quo_ff[DVD_W-1]};
      rem_sub  = rem_sh - {1'b0, div_den_ff};
      div_ge   = (rem_sh >= {1'b0, div_den_ff});
      rem_next = div_ge ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
      quo_next = {div_quo_ff[DVD_W-2:0], div_ge};

      diff     = {{2{rd_data[SAMPLE_W-1]}}, rd_data, 12'b0} - {mean_ff[MEAN_W-1], mean_ff};
      diff_abs = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
      acc_sum  = acc_ff + ACC_W'(mul_ff);
      v_sum    = DVS_W'(quo_next[VAR_W-1:0]) + DVS_W'(eps_ff);

      sq_rb       = sq_res_ff + sq_bit_ff;
      sq_ge       = (sq_v_ff >= sq_rb);
      sq_res_next = sq_ge ? ((sq_res_ff >> 1) + sq_bit_ff) : (sq_res_ff >> 1);

      rnd      = (PROD_W+1)'(mul_ff) + ((PROD_W+1)'(1) << 31);
      q        = rnd[PROD_W:32];
      is_last  = ((CW'(idx_ff) + CW'(1)) == n_ff);
      mean_mag = quo_next[MAG_W-1:0];
   end

   always_comb begin
      state_in     = state_ff;
      len_in       = len_ff;
      eps_in       = eps_ff;
      load_cnt_in  = load_cnt_ff;
      sum_in       = sum_ff;
      n_in         = n_ff;
      idx_in       = idx_ff;
      pass_in      = pass_ff;
      mean_in      = mean_ff;
      a_in         = a_ff;
      mul_in       = mul_ff;
      acc_in       = acc_ff;
      inv_in       = inv_ff;
      div_rem_in   = div_rem_ff;
      div_quo_in   = div_quo_ff;
      div_den_in   = div_den_ff;
      div_cnt_in   = div_cnt_ff;
      sq_v_in      = sq_v_ff;
      sq_res_in    = sq_res_ff;
      sq_bit_in    = sq_bit_ff;
      sq_cnt_in    = sq_cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      rsp_last_in  = rsp_last_ff;
      rd_en        = 1'b0;

      if (cfg_write) begin
         case (paddr[2])
            REG_LENGTH:  len_in = pwdata[LEN_W-1:0];
            REG_EPSILON: eps_in = pwdata[EPS_W-1:0];
            default:     len_in = len_ff;
         endcase
      end

      case (state_ff)
         ST_LOAD: begin
            if (accept) begin
               load_cnt_in = cnt_next;
               sum_in      = sum_next;
               if (cnt_next >= eff_len) begin
                  n_in       = cnt_next;
                  div_quo_in = DVD_W'(mean_dvd);
                  div_rem_in = '0;
                  div_den_in = DVS_W'(cnt_next);
                  div_cnt_in = 6'(DVD_W - 1);
                  state_in   = ST_MEAN;
               end
            end
         end
         ST_MEAN: begin
            div_rem_in = rem_next;
            div_quo_in = quo_next;
            div_cnt_in = div_cnt_ff - 6'd1;
            if (div_cnt_ff == '0) begin
               mean_in  = sum_ff[SUM_W-1] ? -$signed({1'b0, mean_mag[MAG_W-2:0]})
                                          : $signed({1'b0, mean_mag[MAG_W-2:0]});
               pass_in  = 1'b0;
               idx_in   = '0;
               acc_in   = ACC_W'(n_ff) << 23;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            rd_en    = 1'b1;
            state_in = ST_DIFF;
         end
         ST_DIFF: begin
            a_in     = diff_abs[MAG_W-1:0];
            state_in = ST_MUL;
         end
         ST_MUL: begin
            mul_in   = a_ff * (pass_ff ? inv_ff : INV_W'(a_ff));
            state_in = pass_ff ? ST_EMIT : ST_ACC;
         end
         ST_ACC: begin
            acc_in = acc_sum;
            if (is_last) begin
               div_quo_in = DVD_W'(acc_sum[ACC_W-1:24]);
               div_rem_in = '0;
               div_den_in = DVS_W'(n_ff);
               div_cnt_in = 6'(DVD_W - 1);
               state_in   = ST_VAR;
            end else begin
               idx_in   = idx_ff + AW'(1);
               state_in = ST_READ;
            end
         end
         ST_VAR: begin
            div_rem_in = rem_next;
            div_quo_in = quo_next;
            div_cnt_in = div_cnt_ff - 6'd1;
            if (div_cnt_ff == '0) begin
               div_quo_in = DVD_W'(1) << 62;
               div_rem_in = '0;
               div_den_in = (v_sum == '0) ? DVS_W'(1) : v_sum;
               div_cnt_in = 6'(DVD_W - 1);
               state_in   = ST_RECIP;
            end
         end
         ST_RECIP: begin
            div_rem_in = rem_next;
            div_quo_in = quo_next;
            div_cnt_in = div_cnt_ff - 6'd1;
            if (div_cnt_ff == '0) begin
               sq_v_in   = quo_next;
               sq_res_in = '0;
               sq_bit_in = DVD_W'(1) << 62;
               sq_cnt_in = 5'd31;
               state_in  = ST_SQRT;
            end
         end
         ST_SQRT: begin
            sq_v_in   = sq_ge ? (sq_v_ff - sq_rb) : sq_v_ff;
            sq_res_in = sq_res_next;
            sq_bit_in = sq_bit_ff >> 2;
            sq_cnt_in = sq_cnt_ff - 5'd1;
            if (sq_cnt_ff == '0) begin
               inv_in   = sq_res_next[INV_W-1:0];
               pass_in  = 1'b1;
               idx_in   = '0;
               state_in = ST_READ;
            end
         end
         ST_EMIT: begin
            if (neg_ff) begin
               rsp_value_in = (q > DIFF_W'(32768)) ? 16'h8000 : SAMPLE_W'(-q[SAMPLE_W-1:0]);
            end else begin
               rsp_value_in = (q > DIFF_W'(32767)) ? 16'h7fff : q[SAMPLE_W-1:0];
            end
            rsp_last_in  = is_last;
            rsp_valid_in = 1'b1;
            state_in     = ST_WAIT;
         end
         ST_WAIT: begin
            if (!rsp_stall) begin
               rsp_valid_in = 1'b0;
               if (rsp_last_ff) begin
                  load_cnt_in = '0;
                  sum_in      = '0;
                  state_in    = ST_LOAD;
               end else begin
                  idx_in   = idx_ff + AW'(1);
                  state_in = ST_READ;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   assign neg_in = (state_ff == ST_DIFF) ? diff[DIFF_W-1] : neg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         len_ff       <= LEN_RESET;
         eps_ff       <= EPS_RESET;
         load_cnt_ff  <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         eps_ff       <= eps_in;
         load_cnt_ff  <= load_cnt_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff         <= n_in;
      idx_ff       <= idx_in;
      pass_ff      <= pass_in;
      mean_ff      <= mean_in;
      a_ff         <= a_in;
      neg_ff       <= neg_in;
      mul_ff       <= mul_in;
      acc_ff       <= acc_in;
      inv_ff       <= inv_in;
      div_rem_ff   <= div_rem_in;
      div_quo_ff   <= div_quo_in;
      div_den_ff   <= div_den_in;
      div_cnt_ff   <= div_cnt_in;
      sq_v_ff      <= sq_v_in;
      sq_res_ff    <= sq_res_in;
      sq_bit_ff    <= sq_bit_in;
      sq_cnt_ff    <= sq_cnt_in;
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
   end

endmodule

### rtl/vln_checker.sv
// ----------------------------------------------------------------------------
// vln_checker
// Port-level checks for the vector layer normalize unit.
// ----------------------------------------------------------------------------
module vln_checker
   import vln_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                req_stall,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input logic [SAMPLE_W-1:0] rsp_normalized_value,
   input logic                rsp_last
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_normalized_value)
                                 && $stable(rsp_last))
      else $error("rsp beat changed while stalled");

   a_no_load_during_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("req accepted while a rsp beat is pending");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !req_stall && !rsp_valid)
      else $error("not ready to load after reset");

   a_one_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall |=> !rsp_valid)
      else $error("rsp beat repeated back to back");

endmodule

bind vector_layer_normalize_unit vln_checker u_vln_checker (
   .clock                (clock),
   .reset                (reset),
   .req_stall            (req_stall),
   .rsp_valid            (rsp_valid),
   .rsp_stall            (rsp_stall),
   .rsp_normalized_value (rsp_normalized_value),
   .rsp_last             (rsp_last)
);

### tb/sv/vln_checker.sv
// ----------------------------------------------------------------------------
// vln_scoreboard
// Watches the sample and result channels of the vector layer normalize unit,
// predicts each normalized vector in fixed point and compares result beats.
// ----------------------------------------------------------------------------
module vln_scoreboard
   import vln_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_stall,
   input  logic signed [SAMPLE_W-1:0] req_sample,
   input  logic                       rsp_valid,
   input  logic                       rsp_stall,
   input  logic signed [SAMPLE_W-1:0] rsp_normalized_value,
   input  logic                       rsp_last,
   input  logic [LEN_W-1:0]           cfg_length,
   input  logic [EPS_W-1:0]           cfg_epsilon,
   output int                         fail_count,
   output int                         pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] value;
      logic                       last;
   } norm_beat_type;

   norm_beat_type      expected_norm[$];
   logic signed [15:0] loaded[MAX_LEN_DEF];
   int                 load_cnt;
   longint             sum_acc;

   initial fail_count = 0;
   initial pending = 0;

   task automatic report(input string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      fail_count++;
   endtask

   function automatic longint unsigned int_sqrt(input longint unsigned v);
      longint unsigned res, bitv;
      res  = 0;
      bitv = 64'h1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v   = v - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   task automatic normalize_vector();
      int              n;
      longint          scaled, mean, d;
      longint unsigned mag, var_acc, den, var_q, v, inv, a, q;
      norm_beat_type   b;
      n = load_cnt;
      scaled = sum_acc * 4096;
      mag = (scaled < 0) ? -scaled : scaled;
      mag = (mag + n / 2) / n;
      mean = (scaled < 0) ? -longint'(mag) : longint'(mag);
      var_acc = 0;
      for (int i = 0; i < n; i++) begin
         d = longint'(loaded[i]) * 4096 - mean;
         a = (d < 0) ? -d : d;
         var_acc += a * a;
      end
      den = longint'(n) << 24;
      var_q = (var_acc + den / 2) / den;
      v = var_q + cfg_epsilon;
      if (v == 0) v = 1;
      inv = int_sqrt((64'h1 << 62) / v);
      for (int i = 0; i < n; i++) begin
         d = longint'(loaded[i]) * 4096 - mean;
         a = (d < 0) ? -d : d;
         q = (a * inv + (64'h1 << 31)) >> 32;
         if (d < 0) b.value = (q > 32768) ? -16'sd32768 : -16'(q);
         else       b.value = (q > 32767) ? 16'sd32767 : 16'(q);
         b.last = (i + 1 == n);
         expected_norm.push_back(b);
      end
      load_cnt = 0;
      sum_acc  = 0;
   endtask

   always @(posedge clock) begin
      int            eff;
      norm_beat_type e;
      if (reset) begin
         load_cnt = 0;
         sum_acc  = 0;
      end else begin
         if (req_valid && !req_stall) begin
            if (load_cnt >= MAX_LEN_DEF) load_cnt = MAX_LEN_DEF - 1;
            loaded[load_cnt] = req_sample;
            load_cnt++;
            sum_acc += req_sample;
            eff = cfg_length;
            if (eff < 1) eff = 1;
            if (eff > MAX_LEN_DEF) eff = MAX_LEN_DEF;
            if (load_cnt >= eff) normalize_vector();
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_norm.size() == 0) begin
               report($sformatf("unexpected beat value=%0d last=%0b",
                                rsp_normalized_value, rsp_last));
            end else begin
               e = expected_norm.pop_front();
               if (rsp_normalized_value !== e.value)
                  report($sformatf("value got %0d exp %0d",
                                   rsp_normalized_value, e.value));
               if (rsp_last !== e.last)
                  report($sformatf("last got %0b exp %0b", rsp_last, e.last));
            end
         end
      end
      pending = expected_norm.size();
   end
endmodule

### tb/sv/tb_vector_layer_normalize_unit.sv
// ----------------------------------------------------------------------------
// tb_vector_layer_normalize_unit
// Drives sample vectors and register settings into the normalize unit with
// random idle and stall, and reports the verdict from the checker.
// ----------------------------------------------------------------------------
module tb_vector_layer_normalize_unit;
   import vln_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint CYCLE_LIMIT = 3000000;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic signed [SAMPLE_W-1:0] req_sample = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic signed [SAMPLE_W-1:0] rsp_normalized_value;
   logic                       rsp_last;
   logic                       csr_psel = 1'b0;
   logic                       csr_penable = 1'b0;
   logic                       csr_pwrite = 1'b0;
   logic [PADDR_W-1:0]         csr_paddr = '0;
   logic [PDATA_W-1:0]         csr_pwdata = '0;
   logic [PDATA_W-1:0]         csr_prdata;
   logic                       csr_pready;
   logic [LEN_W-1:0]           cur_length = LEN_RESET;
   logic [EPS_W-1:0]           cur_epsilon = EPS_RESET;
   int                         fail_count, pending;
   longint                     cycle_count = 0;
   bit                         calm = 1'b0;

   always #2 clock = ~clock;

   vector_layer_normalize_unit dut (
      .clock, .reset, .req_valid, .req_stall, .req_sample,
      .rsp_valid, .rsp_stall, .rsp_normalized_value, .rsp_last,
      .psel(csr_psel), .penable(csr_penable), .pwrite(csr_pwrite),
      .paddr(csr_paddr), .pwdata(csr_pwdata), .prdata(csr_prdata),
      .pready(csr_pready)
   );

   vln_scoreboard chk (
      .clock, .reset, .req_valid, .req_stall, .req_sample,
      .rsp_valid, .rsp_stall, .rsp_normalized_value, .rsp_last,
      .cfg_length(cur_length), .cfg_epsilon(cur_epsilon),
      .fail_count, .pending
   );

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   always @(posedge clock)
      rsp_stall <= (!calm && $urandom_range(99) < 36);

   task automatic write_reg(input logic reg_sel, input logic [31:0] data);
      @(posedge clock);
      csr_psel   <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr  <= PADDR_W'({reg_sel, 2'b00});
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (reg_sel == REG_LENGTH) cur_length = data[LEN_W-1:0];
      else                       cur_epsilon = data[EPS_W-1:0];
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic send_sample(input logic signed [15:0] s);
      while (!calm && $urandom_range(99) < 36) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_sample <= s;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   function automatic logic signed [15:0] rand_sample(input int mode);
      case (mode)
         0: return 16'($urandom);
         1: return $signed(16'($urandom_range(200))) - 16'sd100;
         2: return ($urandom_range(1)) ? 16'sh7FFF : 16'sh8000;
         default: return 16'sd1000 + $signed(16'($urandom_range(3)));
      endcase
   endfunction

   initial begin
      int len, mode;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      // directed: short vectors with extreme and flat content, and one full-length ramp
      write_reg(REG_LENGTH, 4);
      write_reg(REG_EPSILON, 0);
      repeat (4) send_sample(16'sd500);
      send_sample(16'sh7FFF); send_sample(16'sh8000);
      send_sample(16'sh7FFF); send_sample(16'sh8000);
      drain();
      write_reg(REG_LENGTH, 0);
      send_sample(16'sh8000); send_sample(16'sh7FFF);
      drain();
      write_reg(REG_EPSILON, 16'hFFFF);
      write_reg(REG_LENGTH, 7'h7F);
      for (int i = 0; i < 64; i++) send_sample(16'(i * 1021 - 32000));
      drain();
      write_reg(REG_LENGTH, 8);
      write_reg(REG_EPSILON, EPS_RESET);
      repeat (3) send_sample(16'sh5555);
      drain();
      write_reg(REG_LENGTH, 2);
      send_sample(16'shAAAA);
      drain();
      // random vectors, calm stretch in the middle
      for (int k = 0; k < 18; k++) begin
         calm = (k >= 7 && k < 11);
         len = ($urandom_range(9) == 0) ? 64 : $urandom_range(16, 1);
         write_reg(REG_LENGTH, len);
         write_reg(REG_EPSILON, ($urandom_range(3) == 0) ? $urandom_range(65535) :
                                 $urandom_range(300));
         mode = $urandom_range(3);
         for (int i = 0; i < len; i++) send_sample(rand_sample(mode));
         drain();
      end
      calm = 1'b0;
      drain();
      if (fail_count == 0) $display("Testbench completed without errors");
      else                 $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule
